FILE: rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared sizes, codes and types of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TIME_W   = 32;
  localparam int ID_W     = 16;
  localparam int TAG_W    = 16;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;

  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTHING   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_CANCELLED = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_SHIFT
  } cell_cmd_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_cmd_t         cmd;
    logic [TIME_W-1:0] key;
    logic [ID_W-1:0]   tid;
    entry_t            fresh;
  } chain_ctl_t;

endpackage

FILE: rtl/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted timer row: holds an entry and trades it with its
// neighbors on insert, remove and shift.
// ----------------------------------------------------------------------------
module dtq_cell import dtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  input  entry_t     left_ent,
  input  logic       left_valid,
  input  logic       left_after,
  input  entry_t     right_ent,
  input  logic       right_valid,
  input  logic       found_in,
  output logic       valid,
  output entry_t     ent,
  output logic       after,
  output logic       found_out
);

  logic   valid_next;
  entry_t ent_next;

  // The new deadline goes in front of the first slot that is empty or later.
  assign after     = !valid || (ent.deadline > ctl.key);
  assign found_out = found_in || (valid && (ent.id == ctl.tid));

  always_comb begin
    valid_next = valid;
    ent_next   = ent;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (left_after) begin
          valid_next = left_valid;
          ent_next   = left_ent;
        end else if (after) begin
          valid_next = 1'b1;
          ent_next   = ctl.fresh;
        end
      end
      CMD_REMOVE: begin
        if (found_out) begin
          valid_next = right_valid;
          ent_next   = right_ent;
        end
      end
      CMD_SHIFT: begin
        valid_next = right_valid;
        ent_next   = right_ent;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    ent <= ent_next;
  end

endmodule

FILE: rtl/dtq_chain.sv
// ----------------------------------------------------------------------------
// dtq_chain
// The row of timer cells, kept sorted by deadline with the earliest at the
// head.
// ----------------------------------------------------------------------------
module dtq_chain import dtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  output logic       head_valid,
  output entry_t     head,
  output logic       second_valid,
  output logic       found
);

  logic   valid_w [CAPACITY];
  entry_t ent_w   [CAPACITY];
  logic   after_w [CAPACITY];
  logic   found_w [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t l_ent;
    logic   l_valid;
    logic   l_after;
    logic   l_found;
    entry_t r_ent;
    logic   r_valid;

    if (i == 0) begin : g_first
      assign l_ent   = '0;
      assign l_valid = 1'b0;
      assign l_after = 1'b0;
      assign l_found = 1'b0;
    end else begin : g_inner_l
      assign l_ent   = ent_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_after = after_w[i-1];
      assign l_found = found_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_ent   = ent_w[i+1];
      assign r_valid = valid_w[i+1];
    end

    dtq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_ent    (l_ent),
      .left_valid  (l_valid),
      .left_after  (l_after),
      .right_ent   (r_ent),
      .right_valid (r_valid),
      .found_in    (l_found),
      .valid       (valid_w[i]),
      .ent         (ent_w[i]),
      .after       (after_w[i]),
      .found_out   (found_w[i])
    );
  end

  assign head_valid   = valid_w[0];
  assign head         = ent_w[0];
  assign second_valid = valid_w[1];
  assign found        = found_w[CAPACITY-1];

endmodule

FILE: rtl/deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// Bounded queue of pending timers sorted by deadline, with add, cancel,
// pop of expired entries, query of the next deadline and clear.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ------------------------------------
// in       input      in_valid / in_ready  mode deadline relative handler_tag
//                                          cancel_id now
// out      output     out_valid/out_ready  status assigned_id tag_out
//                                          next_deadline remaining due
//                                          pending last
//
// Each beat is captured in the cycle it is accepted, where a relative
// deadline is summed and saturated; in the exec state one command is then
// applied to the whole cell row and the result register is loaded. No new
// input beat is taken until the block is back in idle. A clear of a
// non-empty row loads nothing in the exec state and then gives one output
// beat per entry shifted out of the head of the row.
// Reset is synchronous and empties the row and sets the id counter to one.
// A stalled output holds the row: the command waits until the result
// register is free, while a new input beat can still be accepted when idle.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit import dtq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [TIME_W-1:0] deadline,
  input  logic              relative,
  input  logic [TAG_W-1:0]  handler_tag,
  input  logic [ID_W-1:0]   cancel_id,
  input  logic [TIME_W-1:0] now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [ID_W-1:0]   assigned_id,
  output logic [TAG_W-1:0]  tag_out,
  output logic [TIME_W-1:0] next_deadline,
  output logic [TIME_W-1:0] remaining,
  output logic              due,
  output logic [CNT_W-1:0]  pending,
  output logic              last
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t state, state_next;

  // Captured operation.
  logic [MODE_W-1:0] op_mode;
  logic [TIME_W-1:0] op_d;
  logic [TAG_W-1:0]  op_tag;
  logic [ID_W-1:0]   op_tid;
  logic [TIME_W-1:0] op_now;

  logic [CNT_W-1:0] count, count_next;
  logic [ID_W-1:0]  id_ctr, id_ctr_next;

  logic [TIME_W:0]   rel_sum;
  logic [TIME_W-1:0] d_in;

  chain_ctl_t ctl;
  logic       head_valid;
  entry_t     head;
  logic       second_valid;
  logic       found;

  logic              out_free;
  logic              load;
  logic [STAT_W-1:0] status_next;
  logic [ID_W-1:0]   assigned_id_next;
  logic [TAG_W-1:0]  tag_out_next;
  logic [TIME_W-1:0] next_deadline_next;
  logic [TIME_W-1:0] remaining_next;
  logic              due_next;
  logic [CNT_W-1:0]  pending_next;
  logic              last_next;

  logic full;
  logic head_due;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Relative deadlines saturate at the top of the time range.
  assign rel_sum = {1'b0, now} + {1'b0, deadline};
  assign d_in    = !relative ? deadline :
                   (rel_sum[TIME_W] ? '1 : rel_sum[TIME_W-1:0]);

  assign full     = (count == CNT_W'(CAPACITY));
  assign head_due = head_valid && (head.deadline <= op_now);

  dtq_chain u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .head_valid   (head_valid),
    .head         (head),
    .second_valid (second_valid),
    .found        (found)
  );

  always_comb begin
    state_next         = state;
    count_next         = count;
    id_ctr_next        = id_ctr;
    ctl.cmd            = CMD_HOLD;
    ctl.key            = op_d;
    ctl.tid            = op_tid;
    ctl.fresh.deadline = op_d;
    ctl.fresh.id       = id_ctr;
    ctl.fresh.tag      = op_tag;
    load               = 1'b0;
    status_next        = ST_NOTHING;
    assigned_id_next   = '0;
    tag_out_next       = '0;
    next_deadline_next = '0;
    remaining_next     = '0;
    due_next           = 1'b0;
    pending_next       = count;
    last_next          = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          unique case (op_mode)
            MODE_ADD: begin
              load = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                ctl.cmd          = CMD_INSERT;
                status_next      = ST_DONE;
                assigned_id_next = id_ctr;
                count_next       = count + 1'b1;
                pending_next     = count + 1'b1;
                // Id zero is never handed out.
                id_ctr_next      = (id_ctr == '1) ? ID_W'(1) : id_ctr + 1'b1;
              end
            end
            MODE_CANCEL: begin
              load    = 1'b1;
              ctl.cmd = CMD_REMOVE;
              if (found) begin
                status_next  = ST_DONE;
                count_next   = count - 1'b1;
                pending_next = count - 1'b1;
              end
            end
            MODE_POP: begin
              load = 1'b1;
              if (head_due) begin
                ctl.cmd          = CMD_SHIFT;
                status_next      = ST_DONE;
                assigned_id_next = head.id;
                tag_out_next     = head.tag;
                count_next       = count - 1'b1;
                pending_next     = count - 1'b1;
              end
            end
            MODE_QUERY: begin
              load = 1'b1;
              if (head_valid) begin
                status_next        = ST_DONE;
                next_deadline_next = head.deadline;
                due_next           = head_due;
                remaining_next     = head_due ? '0 : head.deadline - op_now;
              end
            end
            MODE_CLEAR: begin
              if (head_valid) begin
                state_next = S_CLEAR;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (out_free) begin
          load             = 1'b1;
          ctl.cmd          = CMD_SHIFT;
          status_next      = ST_CANCELLED;
          assigned_id_next = head.id;
          tag_out_next     = head.tag;
          pending_next     = '0;
          last_next        = !second_valid;
          if (!second_valid) begin
            count_next = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      id_ctr    <= ID_W'(1);
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      id_ctr <= id_ctr_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode <= mode;
      op_d    <= d_in;
      op_tag  <= handler_tag;
      op_tid  <= cancel_id;
      op_now  <= now;
    end
    if (load) begin
      status        <= status_next;
      assigned_id   <= assigned_id_next;
      tag_out       <= tag_out_next;
      next_deadline <= next_deadline_next;
      remaining     <= remaining_next;
      due           <= due_next;
      pending       <= pending_next;
      last          <= last_next;
    end
  end

endmodule

FILE: rtl/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the deadline timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker import dtq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic [ID_W-1:0]   assigned_id,
  input logic [TIME_W-1:0] remaining,
  input logic              due,
  input logic [CNT_W-1:0]  pending
);

  // A stalled output beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A full refusal reports a full queue and hands out no id.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |->
      (pending == CNT_W'(CAPACITY)) && (assigned_id == '0))
    else $error("full status with wrong count or id");

  // Entries given out by a clear leave the queue empty and carry a real id.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_CANCELLED) |->
      (pending == '0) && (assigned_id != '0))
    else $error("cancelled entry with pending count or zero id");

  // A due query reports nothing remaining.
  a_due: assert property (@(posedge clk) disable iff (rst)
    out_valid && due |-> (remaining == '0) && (status == ST_DONE))
    else $error("due flag with remaining ticks");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (.*);

FILE: dv/tb_deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue_unit
// Self-checking testbench for the deadline timer queue. A shadow copy of the
// sorted timer row predicts every result beat. A checker compares each
// accepted output beat, field by field, with the oldest prediction. The tests
// cover the empty queue, deadline and tie ordering, expiry, a full queue under
// output backpressure and random mixed traffic.
// ----------------------------------------------------------------------------
module tb_deadline_timer_queue_unit import dtq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog fires after this many cycles without a beat on either side.
  localparam int WATCHDOG_LIMIT = 2000;
  // Only the first few mismatches are printed in full.
  localparam int MAX_REPORTS    = 10;
  // Cycles to idle at the end so that a stray result beat still shows up.
  localparam int DRAIN_CYCLES   = 20;
  // Length of the long receiver hold-off that fills the block up.
  localparam int LONG_HOLD      = 80;

  // One output beat as the block should present it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] next_dl;
    logic [TIME_W-1:0] rem;
    logic              due;
    logic [CNT_W-1:0]  pending;
    logic              last;
  } timer_result_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] mode        = MODE_QUERY;
  logic [TIME_W-1:0] deadline    = '0;
  logic              relative    = 1'b0;
  logic [TAG_W-1:0]  handler_tag = '0;
  logic [ID_W-1:0]   cancel_id   = '0;
  logic [TIME_W-1:0] now         = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   assigned_id;
  logic [TAG_W-1:0]  tag_out;
  logic [TIME_W-1:0] next_deadline;
  logic [TIME_W-1:0] remaining;
  logic              due;
  logic [CNT_W-1:0]  pending;
  logic              last;

  // Shadow of the timer row: valid entries always sit in slots 0..count-1,
  // sorted by deadline, equal deadlines in arrival order.
  entry_t          shadow_slots [CAPACITY];
  int              shadow_count   = 0;
  logic [ID_W-1:0] shadow_next_id = ID_W'(1);

  // Result beats predicted but not yet seen on the output, oldest first.
  timer_result_t   queued_timer_results [$];

  int unsigned     mismatch_count = 0;
  int unsigned     items_sent     = 0;
  int unsigned     results_seen   = 0;
  int unsigned     stall_cycles   = 0;

  // Idle controls: each side draws a random wait per beat while its flag is
  // set. rx_hold forces a long receiver hold-off.
  bit              tx_idle_en     = 1'b1;
  bit              rx_idle_en     = 1'b1;
  int              rx_hold        = 0;

  deadline_timer_queue_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .deadline      (deadline),
    .relative      (relative),
    .handler_tag   (handler_tag),
    .cancel_id     (cancel_id),
    .now           (now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .assigned_id   (assigned_id),
    .tag_out       (tag_out),
    .next_deadline (next_deadline),
    .remaining     (remaining),
    .due           (due),
    .pending       (pending),
    .last          (last)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [ID_W-1:0] any16();
    return ID_W'($urandom);
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void post_result(input logic [STAT_W-1:0] st,
                                      input logic [ID_W-1:0] id,
                                      input logic [TAG_W-1:0] tag,
                                      input logic [TIME_W-1:0] next_dl,
                                      input logic [TIME_W-1:0] rem,
                                      input logic due_flag, input int pend,
                                      input logic last_flag);
    timer_result_t r;
    r.status  = st;
    r.id      = id;
    r.tag     = tag;
    r.next_dl = next_dl;
    r.rem     = rem;
    r.due     = due_flag;
    r.pending = CNT_W'(pend);
    r.last    = last_flag;
    queued_timer_results.push_back(r);
  endfunction

  // Closes the gap left by a removed entry, like the chain shifting up.
  function automatic void drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
    shadow_count--;
  endfunction

  // Applies one accepted operation to the shadow row and queues the result
  // beats that it must produce.
  function automatic void apply_timer_op(input logic [MODE_W-1:0] md,
                                         input logic [TIME_W-1:0] dl,
                                         input logic rel,
                                         input logic [TAG_W-1:0] tag,
                                         input logic [ID_W-1:0] tid,
                                         input logic [TIME_W-1:0] nw);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] fire_at;
    entry_t            head;
    int                pos;
    int                hit;
    int                i;
    case (md)
      MODE_ADD: begin
        if (shadow_count >= CAPACITY) begin
          // A full queue refuses the add; the id counter keeps its value.
          post_result(ST_FULL, '0, '0, '0, '0, 1'b0, shadow_count, 1'b1);
        end else begin
          // A relative deadline saturates at the top of the time range.
          sum     = {1'b0, nw} + {1'b0, dl};
          fire_at = !rel ? dl : (sum[TIME_W] ? '1 : sum[TIME_W-1:0]);
          pos = 0;
          while (pos < shadow_count && shadow_slots[pos].deadline <= fire_at) pos++;
          for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[pos].deadline = fire_at;
          shadow_slots[pos].id       = shadow_next_id;
          shadow_slots[pos].tag      = tag;
          shadow_count++;
          post_result(ST_DONE, shadow_next_id, '0, '0, '0, 1'b0, shadow_count, 1'b1);
          // Id zero is never handed out: the counter wraps to one.
          shadow_next_id = (shadow_next_id == '1) ? ID_W'(1) : shadow_next_id + 1'b1;
        end
      end
      MODE_CANCEL: begin
        // With a duplicate id the earliest-ordered holder goes.
        hit = -1;
        for (i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_slots[i].id == tid) hit = i;
        end
        if (hit >= 0) begin
          drop_slot(hit);
          post_result(ST_DONE, '0, '0, '0, '0, 1'b0, shadow_count, 1'b1);
        end else begin
          post_result(ST_NOTHING, '0, '0, '0, '0, 1'b0, shadow_count, 1'b1);
        end
      end
      MODE_POP: begin
        if (shadow_count == 0 || shadow_slots[0].deadline > nw) begin
          post_result(ST_NOTHING, '0, '0, '0, '0, 1'b0, shadow_count, 1'b1);
        end else begin
          head = shadow_slots[0];
          drop_slot(0);
          post_result(ST_DONE, head.id, head.tag, '0, '0, 1'b0, shadow_count, 1'b1);
        end
      end
      MODE_QUERY: begin
        if (shadow_count == 0) begin
          post_result(ST_NOTHING, '0, '0, '0, '0, 1'b0, 0, 1'b1);
        end else if (shadow_slots[0].deadline <= nw) begin
          post_result(ST_DONE, '0, '0, shadow_slots[0].deadline, '0, 1'b1,
                      shadow_count, 1'b1);
        end else begin
          post_result(ST_DONE, '0, '0, shadow_slots[0].deadline,
                      shadow_slots[0].deadline - nw, 1'b0, shadow_count, 1'b1);
        end
      end
      MODE_CLEAR: begin
        // Every entry comes out as cancelled, in queue order.
        if (shadow_count == 0) begin
          post_result(ST_NOTHING, '0, '0, '0, '0, 1'b0, 0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            post_result(ST_CANCELLED, shadow_slots[i].id, shadow_slots[i].tag, '0, '0,
                        1'b0, 0, (i + 1 == shadow_count));
          end
          shadow_count = 0;
        end
      end
      default: begin
        // Unused mode codes report nothing and leave the row alone.
        post_result(ST_NOTHING, '0, '0, '0, '0, 1'b0, shadow_count, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one beat and waits until it is taken. After acceptance in_valid is
  // left high for this time step only: the next call either replaces the
  // payload at once or drops valid for its gap, and any other wait goes
  // through release_input, so valid is never lowered and raised in one step.
  task automatic send_item(input logic [MODE_W-1:0] md, input logic [TIME_W-1:0] dl,
                           input logic rel, input logic [TAG_W-1:0] tag,
                           input logic [ID_W-1:0] tid, input logic [TIME_W-1:0] nw);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= md;
    deadline    <= dl;
    relative    <= rel;
    handler_tag <= tag;
    cancel_id   <= tid;
    now         <= nw;
    do @(posedge clk); while (!in_ready);
    apply_timer_op(md, dl, rel, tag, tid, nw);
    items_sent++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The sender stays quiet until every predicted beat has come out.
  task automatic wait_drained();
    release_input();
    while (queued_timer_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // The receiver draws a wait after each accepted beat. A long hold-off set
  // by a test overrides it.
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) wait_left = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void note_mismatch(input string what, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // Each accepted output beat is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (queued_timer_results.size() == 0) begin
        note_mismatch("unexpected beat status", '0, status);
      end else begin
        want = queued_timer_results.pop_front();
        if (status !== want.status) note_mismatch("status", want.status, status);
        if (assigned_id !== want.id) note_mismatch("assigned_id", want.id, assigned_id);
        if (tag_out !== want.tag) note_mismatch("tag_out", want.tag, tag_out);
        if (next_deadline !== want.next_dl) begin
          note_mismatch("next_deadline", want.next_dl, next_deadline);
        end
        if (remaining !== want.rem) note_mismatch("remaining", want.rem, remaining);
        if (due !== want.due) note_mismatch("due", want.due, due);
        if (pending !== want.pending) note_mismatch("pending", want.pending, pending);
        if (last !== want.last) note_mismatch("last", want.last, last);
      end
    end
  end

  // A run that stops moving ends here.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Query, pop, clear and cancel on an empty queue, plus the unused mode codes.
  task automatic test_empty_queue();
    int k;
    send_item(MODE_QUERY, $urandom, any_bit(), any16(), any16(), 32'h0000_1234);
    send_item(MODE_POP, $urandom, any_bit(), any16(), any16(), '1);
    send_item(MODE_CLEAR, $urandom, any_bit(), any16(), any16(), $urandom);
    send_item(MODE_CANCEL, $urandom, any_bit(), any16(), '1, $urandom);
    send_item(MODE_CANCEL, $urandom, any_bit(), any16(), '0, $urandom);
    for (k = 1; k <= 3; k++) begin
      send_item(MODE_CLEAR + MODE_W'(k), $urandom, any_bit(), any16(), any16(), $urandom);
    end
  endtask

  // Field extremes, relative saturation, ties, expiry and cancel by id.
  task automatic test_ordering_and_expiry();
    logic [ID_W-1:0] base;
    base = shadow_next_id;
    send_item(MODE_ADD, '1, 1'b0, '1, any16(), $urandom);
    send_item(MODE_ADD, '0, 1'b0, '0, any16(), $urandom);
    // The sum runs past the top of the range and sticks there, tying with
    // the first entry and landing behind it.
    send_item(MODE_ADD, 32'h0000_0100, 1'b1, 16'h1111, any16(), 32'hFFFF_FFF0);
    send_item(MODE_ADD, 32'd50, 1'b1, 16'hA5A5, any16(), 32'd100);
    send_item(MODE_ADD, 32'd150, 1'b0, 16'h5A5A, any16(), '0);
    send_item(MODE_QUERY, $urandom, any_bit(), any16(), any16(), '0);
    send_item(MODE_POP, $urandom, any_bit(), any16(), any16(), '0);
    send_item(MODE_QUERY, $urandom, any_bit(), any16(), any16(), 32'd100);
    send_item(MODE_POP, $urandom, any_bit(), any16(), any16(), 32'd149);
    // Remove the older of the two entries that share deadline 150.
    send_item(MODE_CANCEL, $urandom, any_bit(), any16(), ID_W'(base + 3), $urandom);
    send_item(MODE_POP, $urandom, any_bit(), any16(), any16(), 32'd150);
    send_item(MODE_ADD, '0, 1'b1, 16'h0F0F, any16(), '1);
    send_item(MODE_QUERY, $urandom, any_bit(), any16(), any16(), '1);
    send_item(MODE_CLEAR, $urandom, any_bit(), any16(), any16(), $urandom);
    send_item(MODE_QUERY, $urandom, any_bit(), any16(), any16(), $urandom);
  endtask

  // The receiver holds off while adds keep coming, so the block backs up and
  // stalls its input; the queue then fills and refuses further adds.
  task automatic test_fill_under_backpressure();
    int k;
    wait_drained();
    tx_idle_en = 1'b0;
    rx_hold    = LONG_HOLD;
    for (k = 0; k <= CAPACITY; k++) begin
      // Few distinct deadlines, so ties are common.
      send_item(MODE_ADD, TIME_W'($urandom_range(0, 3) * 1000), 1'b0, any16(), any16(),
                $urandom);
    end
    send_item(MODE_ADD, $urandom, 1'b1, any16(), any16(), $urandom);
    send_item(MODE_QUERY, $urandom, any_bit(), any16(), any16(), 32'd500);
    send_item(MODE_POP, $urandom, any_bit(), any16(), any16(), 32'd2500);
    send_item(MODE_CLEAR, $urandom, any_bit(), any16(), any16(), $urandom);
    tx_idle_en = 1'b1;
  endtask

  // Mixed traffic around a moving current time. Deadlines mostly fall close
  // to it so that pops find due entries; cancels mostly name a pending id.
  task automatic test_random_traffic(input int n_items);
    logic [TIME_W-1:0] clock_now;
    logic [MODE_W-1:0] md;
    logic [TIME_W-1:0] dl;
    logic              rel;
    logic [ID_W-1:0]   tid;
    int unsigned       pick;
    int                k;
    clock_now = $urandom;
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_drained();
      if (k % 25 == 0) begin
        tx_idle_en = (k != 0) && ($urandom_range(0, 2) != 0);
        rx_idle_en = (k != 0) && ($urandom_range(0, 2) != 0);
      end
      clock_now = clock_now + TIME_W'($urandom_range(0, 40));
      if ($urandom_range(0, 19) == 0) clock_now = $urandom;
      dl   = $urandom;
      rel  = any_bit();
      tid  = any16();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        md = MODE_ADD;
        if (rel && $urandom_range(0, 7) != 0) dl = TIME_W'($urandom_range(0, 300));
        if (!rel && $urandom_range(0, 5) != 0) dl = clock_now + $urandom_range(0, 300);
      end else if (pick < 55) begin
        md = MODE_CANCEL;
        if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
          tid = shadow_slots[$urandom_range(0, shadow_count - 1)].id;
        end
      end else if (pick < 78) begin
        md = MODE_POP;
      end else if (pick < 92) begin
        md = MODE_QUERY;
      end else if (pick < 97) begin
        md = MODE_CLEAR;
      end else begin
        md = MODE_CLEAR + MODE_W'($urandom_range(1, 3));
      end
      send_item(md, dl, rel, any16(), tid, clock_now);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : run_tests
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_ordering_and_expiry();
    test_fill_under_backpressure();
    test_random_traffic(66);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d operations and checked %0d result beats (%0d mismatches).",
             items_sent, results_seen, mismatch_count);
    $display("Covered empty queue, ties, saturation, full queue, backpressure, mixed ops.");
    if (mismatch_count == 0 && queued_timer_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/dtq_chain.sv
rtl/deadline_timer_queue_unit.sv
rtl/dtq_checker.sv
dv/tb_deadline_timer_queue_unit.sv
